// ===== design/page_skip_range_filter_top_macros.svh =====
// Assertion macros shared by the page skip range filter modules.
// No dependencies; include this file by its bare name.
`ifndef PAGE_SKIP_RANGE_FILTER_TOP_MACROS_SVH
`define PAGE_SKIP_RANGE_FILTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSKIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSKIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pskip_pkg.sv =====
// Shared types and constants of the page skip range filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pskip_pkg;

  localparam int unsigned PageNoW    = 32;
  localparam int unsigned PageTypeW  = 16;
  localparam int unsigned IndexIdW   = 64;
  localparam int unsigned SegOffsetW = 16;
  localparam int unsigned InDataW    = 224;
  localparam int unsigned OutDataW   = 40;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [PageNoW-1:0] PrimaryRootPage = 32'd3;
  localparam logic [PageTypeW-1:0] IndexPageTypeReset = 16'd17855;
  localparam logic [PageNoW-1:0] SpaceSizeReset = 32'd1;

  localparam logic ActPage = 1'b0;
  localparam logic ActEnd  = 1'b1;

  localparam logic KindVerdict  = 1'b0;
  localparam logic KindEndpoint = 1'b1;

  localparam logic [CfgIndexW-1:0] CfgCompactEnable = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgIndexPageType = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgSpaceSize     = 2'd2;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic                  compact_enable;
    logic [PageTypeW-1:0]  index_page_type;
    logic [PageNoW-1:0]    total_pages;
  } cfg_t;

  typedef struct packed {
    logic                  action;
    logic [PageNoW-1:0]    page_no;
    logic [PageTypeW-1:0]  type_code;
    logic [PageNoW-1:0]    header_free_limit;
    logic [IndexIdW-1:0]   idx_id;
    logic [PageNoW-1:0]    seg_space;
    logic [PageNoW-1:0]    seg_page;
    logic [SegOffsetW-1:0] seg_offset;
  } page_item_t;

  typedef struct packed {
    logic                  has_verdict;
    logic                  has_endpoint;
    logic                  keep;
    logic [PageNoW-1:0]    endpoint;
  } cmd_t;

endpackage

// ===== design/pskip_front.sv =====
// Front end: accepts page items, keeps the learned space state and
// classifies each item into a queue command. Depends on pskip_pkg.
`timescale 1ns / 1ps

module pskip_front (
  input  logic                clk,
  input  logic                rst_n,
  input  pskip_pkg::cfg_t     cfg,
  input  logic                accept,
  input  pskip_pkg::page_item_t item,
  output logic                push,
  output pskip_pkg::cmd_t     cmd
);
  import pskip_pkg::*;

  logic [PageNoW-1:0]  free_limit_r, free_limit_nxt;
  logic [IndexIdW-1:0] primary_id_r, primary_id_nxt;
  logic                primary_found_r, primary_found_nxt;
  logic                compaction_off_r, compaction_off_nxt;
  logic                in_run_r, in_run_nxt;
  logic                skip;
  logic                produce;

  always_comb begin
    free_limit_nxt     = free_limit_r;
    primary_id_nxt     = primary_id_r;
    primary_found_nxt  = primary_found_r;
    compaction_off_nxt = compaction_off_r;
    in_run_nxt         = in_run_r;
    skip               = 1'b0;
    produce            = 1'b1;
    cmd                = '0;

    if (item.action == ActEnd) begin
      produce           = in_run_r;
      in_run_nxt        = 1'b0;
      cmd.has_endpoint  = 1'b1;
      cmd.endpoint      = cfg.total_pages - 32'd1;
    end else if (!cfg.compact_enable || compaction_off_r) begin
      cmd.has_verdict = 1'b1;
      cmd.keep        = 1'b1;
    end else begin
      priority if (item.page_no == '0) begin
        free_limit_nxt = item.header_free_limit;
      end else if (item.page_no == PrimaryRootPage) begin
        if (item.type_code != cfg.index_page_type) begin
          compaction_off_nxt = 1'b1;
        end else begin
          primary_id_nxt    = item.idx_id;
          primary_found_nxt = 1'b1;
        end
      end else if (item.page_no >= free_limit_r) begin
        skip = (free_limit_r != '0);
      end else if (primary_found_r && item.type_code == cfg.index_page_type &&
                   item.idx_id != primary_id_r) begin
        skip = (item.seg_space == '0) && (item.seg_page == '0) &&
               (item.seg_offset == '0);
      end else begin
        skip = 1'b0;
      end
      cmd.has_verdict = 1'b1;
      cmd.keep        = !skip;
      if (skip && !in_run_r) begin
        in_run_nxt       = 1'b1;
        cmd.has_endpoint = 1'b1;
        cmd.endpoint     = item.page_no;
      end else if (!skip && in_run_r) begin
        in_run_nxt       = 1'b0;
        cmd.has_endpoint = 1'b1;
        cmd.endpoint     = item.page_no - 32'd1;
      end
    end
  end

  assign push = accept && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_limit_r     <= '0;
      primary_id_r     <= '0;
      primary_found_r  <= 1'b0;
      compaction_off_r <= 1'b0;
      in_run_r         <= 1'b0;
    end else if (accept) begin
      free_limit_r     <= free_limit_nxt;
      primary_id_r     <= primary_id_nxt;
      primary_found_r  <= primary_found_nxt;
      compaction_off_r <= compaction_off_nxt;
      in_run_r         <= in_run_nxt;
    end
  end

endmodule

// ===== design/pskip_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on pskip_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "page_skip_range_filter_top_macros.svh"

module pskip_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pskip_pkg::cmd_t push_cmd,
  input  logic            pop,
  output pskip_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);
  import pskip_pkg::*;

  cmd_t             entries_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCntW'(QDepth));
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCntW'(1);
      end
    end
  end

  `PSKIP_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full || pop, "push into a full queue")
  `PSKIP_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty, "pop from an empty queue")
  `PSKIP_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !empty, "queue empty after push")

endmodule

// ===== design/pskip_back.sv =====
// Back end: expands queue commands into result transactions through an
// output register. Depends on pskip_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "page_skip_range_filter_top_macros.svh"

module pskip_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pskip_pkg::cmd_t                  head,
  input  logic                             empty,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic                             out_kind,
  output logic                             out_keep,
  output logic [pskip_pkg::PageNoW-1:0]    out_endpoint,
  output logic                             out_last
);
  import pskip_pkg::*;

  logic               valid_r, valid_nxt;
  logic               phase_r, phase_nxt;
  logic               kind_r, kind_nxt;
  logic               keep_r, keep_nxt;
  logic [PageNoW-1:0] endpoint_r, endpoint_nxt;
  logic               last_r, last_nxt;
  logic               load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt    = valid_r;
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    keep_nxt     = keep_r;
    endpoint_nxt = endpoint_r;
    last_nxt     = last_r;
    pop          = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        if (!phase_r && head.has_verdict) begin
          kind_nxt     = KindVerdict;
          keep_nxt     = head.keep;
          endpoint_nxt = '0;
          last_nxt     = !head.has_endpoint;
          phase_nxt    = head.has_endpoint;
          pop          = !head.has_endpoint;
        end else begin
          kind_nxt     = KindEndpoint;
          keep_nxt     = 1'b0;
          endpoint_nxt = head.endpoint;
          last_nxt     = 1'b1;
          phase_nxt    = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    keep_r     <= keep_nxt;
    endpoint_r <= endpoint_nxt;
    last_r     <= last_nxt;
  end

  assign out_tvalid   = valid_r;
  assign out_kind     = kind_r;
  assign out_keep     = keep_r;
  assign out_endpoint = endpoint_r;
  assign out_last     = last_r;

  `PSKIP_ASSERT_NOW(a_phase_pending, clk, rst_n, phase_r, valid_r && !last_r && kind_r == KindVerdict, "pending endpoint without verdict")
  `PSKIP_ASSERT_NOW(a_endpoint_last, clk, rst_n, valid_r && kind_r == KindEndpoint, last_r && !keep_r, "endpoint not final")
  `PSKIP_ASSERT_NOW(a_verdict_zero, clk, rst_n, valid_r && kind_r == KindVerdict, endpoint_r == '0, "verdict with endpoint")

endmodule

// ===== design/page_skip_range_filter_top.sv =====
// Top level of the page skip range filter: configuration registers, port
// packing and the front end, queue and back end. Depends on pskip_pkg.
`timescale 1ns / 1ps

// Page header items enter at up to one per clock cycle; each item's verdict
// and run state are settled in the cycle it is accepted. Results leave
// through a single output register at one per cycle while the receiver is
// ready, so an item that yields a verdict and an endpoint occupies the
// output for both results, and a four-entry command queue between the front
// and back ends absorbs these bursts and output stalls; in_tready drops
// only while that queue is full. With an empty queue and a ready receiver,
// the first result of an item passes through the command queue and then
// the output register. Configuration writes are always accepted.
module page_skip_range_filter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // page number, page type, header free limit, index id, segment space,
  // segment page, segment offset
  input  logic [pskip_pkg::InDataW-1:0]       in_tdata,
  // action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // keep, endpoint, zero fill
  output logic [pskip_pkg::OutDataW-1:0]      out_tdata,
  // kind
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pskip_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [pskip_pkg::CfgDataW-1:0]      cfg_data
);
  import pskip_pkg::*;

  cfg_t               cfg_r;
  page_item_t         item;
  cmd_t               push_cmd;
  cmd_t               head;
  logic               push;
  logic               pop;
  logic               empty;
  logic               full;
  logic               accept;
  logic               out_keep;
  logic [PageNoW-1:0] out_endpoint;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compact_enable  <= 1'b1;
      cfg_r.index_page_type <= IndexPageTypeReset;
      cfg_r.total_pages     <= SpaceSizeReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgCompactEnable: cfg_r.compact_enable  <= cfg_data[0];
        CfgIndexPageType: cfg_r.index_page_type <= cfg_data[PageTypeW-1:0];
        CfgSpaceSize:     cfg_r.total_pages     <= cfg_data[PageNoW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.action            = in_tuser;
  assign item.page_no           = in_tdata[31:0];
  assign item.type_code         = in_tdata[47:32];
  assign item.header_free_limit = in_tdata[79:48];
  assign item.idx_id            = in_tdata[143:80];
  assign item.seg_space         = in_tdata[175:144];
  assign item.seg_page          = in_tdata[207:176];
  assign item.seg_offset        = in_tdata[223:208];

  assign in_tready = !full;
  assign accept    = in_tvalid && !full;

  pskip_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (accept),
    .item   (item),
    .push   (push),
    .cmd    (push_cmd)
  );

  pskip_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  pskip_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_kind     (out_tuser),
    .out_keep     (out_keep),
    .out_endpoint (out_endpoint),
    .out_last     (out_tlast)
  );

  assign out_tdata = {7'd0, out_endpoint, out_keep};

endmodule

// ===== sim/pskip_result_checker.sv =====
// Result checker for the page skip range filter: follows configuration and
// page transactions, predicts each result and compares it with the output.
// Depends on pskip_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module pskip_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pskip_pkg::InDataW-1:0]   in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pskip_pkg::OutDataW-1:0]  out_tdata,
  input  logic                            out_tuser,
  input  logic                            out_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pskip_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pskip_pkg::CfgDataW-1:0]  cfg_data,
  output int unsigned                     mismatches,
  output int unsigned                     results_due
);
  import pskip_pkg::*;

  typedef struct packed {
    logic               kind;
    logic               keep;
    logic [PageNoW-1:0] endpoint;
    logic               last;
  } page_result_t;

  page_result_t due_results[$];

  logic                 cfg_compact;
  logic [PageTypeW-1:0] cfg_index_type;
  logic [PageNoW-1:0]   cfg_space_size;

  logic [PageNoW-1:0]   lim_free;
  logic [IndexIdW-1:0]  primary_id;
  logic                 primary_seen;
  logic                 skipping_halted;
  logic                 run_open;

  initial begin
    mismatches = 0;
    results_due = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_result(input logic kind, input logic keep,
                             input logic [PageNoW-1:0] endpoint, input logic last);
    page_result_t r;
    r.kind = kind;
    r.keep = keep;
    r.endpoint = endpoint;
    r.last = last;
    due_results.push_back(r);
  endtask

  task automatic predict_results(input page_item_t pg);
    logic skip;
    skip = 1'b0;
    if (pg.action == ActEnd) begin
      if (run_open) begin
        run_open = 1'b0;
        push_result(KindEndpoint, 1'b0, cfg_space_size - 32'd1, 1'b1);
      end
      return;
    end
    if (!cfg_compact || skipping_halted) begin
      push_result(KindVerdict, 1'b1, '0, 1'b1);
      return;
    end
    if (pg.page_no == '0) begin
      lim_free = pg.header_free_limit;
    end else if (pg.page_no == PrimaryRootPage) begin
      if (pg.type_code != cfg_index_type) begin
        skipping_halted = 1'b1;
      end else begin
        primary_id = pg.idx_id;
        primary_seen = 1'b1;
      end
    end else if (pg.page_no >= lim_free) begin
      skip = (lim_free != '0);
    end else if (primary_seen && pg.type_code == cfg_index_type &&
                 pg.idx_id != primary_id) begin
      skip = (pg.seg_space == '0 && pg.seg_page == '0 && pg.seg_offset == '0);
    end

    if (skip) begin
      if (!run_open) begin
        run_open = 1'b1;
        push_result(KindVerdict, 1'b0, '0, 1'b0);
        push_result(KindEndpoint, 1'b0, pg.page_no, 1'b1);
      end else begin
        push_result(KindVerdict, 1'b0, '0, 1'b1);
      end
    end else if (run_open) begin
      run_open = 1'b0;
      push_result(KindVerdict, 1'b1, '0, 1'b0);
      push_result(KindEndpoint, 1'b0, pg.page_no - 32'd1, 1'b1);
    end else begin
      push_result(KindVerdict, 1'b1, '0, 1'b1);
    end
  endtask

  always @(posedge clk) begin : watch
    page_item_t   pg;
    page_result_t want;
    if (!rst_n) begin
      cfg_compact = 1'b1;
      cfg_index_type = IndexPageTypeReset;
      cfg_space_size = SpaceSizeReset;
      lim_free = '0;
      primary_id = '0;
      primary_seen = 1'b0;
      skipping_halted = 1'b0;
      run_open = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgCompactEnable: cfg_compact = cfg_data[0];
          CfgIndexPageType: cfg_index_type = cfg_data[PageTypeW-1:0];
          CfgSpaceSize:     cfg_space_size = cfg_data;
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transaction with no prediction waiting");
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind %b, predicted %b", out_tuser, want.kind));
          if (out_tdata[0] !== want.keep)
            report_mismatch($sformatf("keep %b, predicted %b", out_tdata[0], want.keep));
          if (out_tdata[32:1] !== want.endpoint)
            report_mismatch($sformatf("endpoint %h, predicted %h",
                                      out_tdata[32:1], want.endpoint));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %b, predicted %b", out_tlast, want.last));
        end
      end

      if (in_tvalid && in_tready) begin
        pg.action            = in_tuser;
        pg.page_no           = in_tdata[31:0];
        pg.type_code         = in_tdata[47:32];
        pg.header_free_limit = in_tdata[79:48];
        pg.idx_id            = in_tdata[143:80];
        pg.seg_space         = in_tdata[175:144];
        pg.seg_page          = in_tdata[207:176];
        pg.seg_offset        = in_tdata[223:208];
        predict_results(pg);
      end
    end
    results_due = due_results.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the page skip range filter: drives directed and random
// page streams with configuration phases and random stalls on both sides.
// Depends on pskip_pkg, page_skip_range_filter_top and pskip_result_checker.
`timescale 1ns / 1ps

module tb;
  import pskip_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam logic [PageTypeW-1:0] PlainType = 16'h0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  int unsigned mismatches;
  int unsigned results_due;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle = 24;
  int unsigned recv_idle = 82;
  logic [PageTypeW-1:0] cur_index_type = IndexPageTypeReset;
  logic [IndexIdW-1:0]  cur_primary = '0;

  page_skip_range_filter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pskip_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [IndexIdW-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PageTypeW-1:0] other_type();
    logic [PageTypeW-1:0] t;
    t = 16'($urandom);
    if (t == cur_index_type) t = ~t;
    return t;
  endfunction

  function automatic page_item_t make_page(
    input logic [PageNoW-1:0]    page_no,
    input logic [PageTypeW-1:0]  type_code,
    input logic [PageNoW-1:0]    limit_val,
    input logic [IndexIdW-1:0]   idx_id,
    input logic [PageNoW-1:0]    seg_space,
    input logic [PageNoW-1:0]    seg_page,
    input logic [SegOffsetW-1:0] seg_offset
  );
    page_item_t pg;
    pg.action = ActPage;
    pg.page_no = page_no;
    pg.type_code = type_code;
    pg.header_free_limit = limit_val;
    pg.idx_id = idx_id;
    pg.seg_space = seg_space;
    pg.seg_page = seg_page;
    pg.seg_offset = seg_offset;
    return pg;
  endfunction

  function automatic page_item_t make_end();
    page_item_t pg;
    pg = make_page($urandom, 16'($urandom), $urandom, rand_id(), $urandom, $urandom,
                   16'($urandom));
    pg.action = ActEnd;
    return pg;
  endfunction

  // Out-of-order page headers with random content; page 3 keeps the index
  // type so that compaction is not switched off by accident.
  function automatic page_item_t make_noise();
    page_item_t pg;
    pg = make_page($urandom, 16'($urandom), $urandom, rand_id(), $urandom, $urandom,
                   16'($urandom));
    if ($urandom_range(0, 3) == 0) pg.action = ActEnd;
    if (pg.page_no == PrimaryRootPage) pg.type_code = cur_index_type;
    return pg;
  endfunction

  task automatic send_item(input page_item_t pg);
    while ($urandom_range(0, 99) < send_idle) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= pg.action;
    in_tdata  <= {pg.seg_offset, pg.seg_page, pg.seg_space, pg.idx_id,
                  pg.header_free_limit, pg.type_code, pg.page_no};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic ce, input logic [PageTypeW-1:0] ipt,
                               input logic [PageNoW-1:0] space_pages);
    write_reg(CfgCompactEnable, {31'b0, ce});
    write_reg(CfgIndexPageType, {16'b0, ipt});
    write_reg(CfgSpaceSize, space_pages);
    cur_index_type = ipt;
  endtask

  // One space in page order: page 0 with a free limit, page 3 as the primary
  // index root, then a mix of index and other pages, mostly closed by an
  // end-of-space transaction.
  task automatic run_space(input int unsigned n);
    int unsigned p;
    int unsigned r;
    page_item_t pg;
    logic [PageNoW-1:0] fl;
    r = $urandom_range(0, 9);
    cur_primary = (r == 0) ? '0 : (r == 1) ? '1 : rand_id();
    p = 0;
    while (p < n) begin
      if ($urandom_range(0, 99) < 5) send_item(make_noise());
      r = $urandom_range(0, 99);
      if (p == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: fl = '0;
          8:       fl = $urandom;
          9:       fl = '1;
          default: fl = $urandom_range(1, n + 4);
        endcase
        pg = make_page('0, 16'($urandom), fl, rand_id(), $urandom, $urandom, 16'($urandom));
      end else if (p == PrimaryRootPage) begin
        pg = make_page(p, cur_index_type, $urandom, cur_primary, $urandom, $urandom,
                       16'($urandom));
      end else if (r < 60) begin
        pg = make_page(p, cur_index_type, $urandom, (r < 30) ? cur_primary : rand_id(),
                       '0, '0, '0);
        if ($urandom_range(0, 1) == 1) begin
          pg.seg_space  = ($urandom_range(0, 1) == 1) ? $urandom : '0;
          pg.seg_page   = ($urandom_range(0, 1) == 1) ? $urandom : '0;
          pg.seg_offset = ($urandom_range(0, 1) == 1) ? 16'($urandom) : '0;
        end
      end else begin
        pg = make_page(p, other_type(), $urandom, rand_id(), $urandom, $urandom,
                       16'($urandom));
      end
      send_item(pg);
      p = p + (($urandom_range(0, 99) < 3) ? 2 : 1);
    end
    if ($urandom_range(0, 99) < 85) send_item(make_end());
  endtask

  initial begin : stimulus
    int unsigned seg_end;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part; a zero space size makes the closing endpoint wrap.
    apply_setting(1'b1, IndexPageTypeReset, '0);
    send_item(make_page(0, 16'hFFFF, 32'd100, '0, '0, '0, '0));
    send_item(make_page(1, PlainType, '1, '1, '1, '1, '1));
    send_item(make_page(3, IndexPageTypeReset, '0, '1, '0, '0, '0));
    send_item(make_page(4, IndexPageTypeReset, '0, '0, '0, '0, '0));
    send_item(make_page(5, IndexPageTypeReset, '0, 64'd1, '0, '0, '1));
    send_item(make_page(6, IndexPageTypeReset, '0, '1, '0, '0, '0));
    send_item(make_page(7, IndexPageTypeReset, '0, 64'd2, '0, '0, '0));
    send_item(make_end());
    send_item(make_end());
    send_item(make_page(0, IndexPageTypeReset, 32'd10, '0, '0, '0, '0));
    send_item(make_page(12, IndexPageTypeReset, '0, 64'd5, '0, '0, '0));
    send_item(make_page(0, PlainType, '1, '0, '0, '0, '0));
    send_item(make_page('1, PlainType, '0, '0, '0, '0, '0));
    send_item(make_page(32'hFFFF_FFFE, PlainType, '0, '0, '0, '0, '0));
    send_item(make_page(3, IndexPageTypeReset, '0, '0, '0, '0, '0));
    send_item(make_page(8, IndexPageTypeReset, '0, 64'h8000_0000_0000_0000, '1, '0, '0));
    send_item(make_page(9, IndexPageTypeReset, '0, 64'd1, '0, '1, '0));
    send_item(make_page(10, IndexPageTypeReset, '0, '1, '0, '0, '0));
    send_item(make_page(11, IndexPageTypeReset, '0, 64'd3, '0, '0, '0));
    settle_block();
    write_reg(CfgCompactEnable, '0);
    send_item(make_page(12, IndexPageTypeReset, '0, 64'd3, '0, '0, '0));
    send_item(make_page(3, PlainType, '0, '0, '0, '0, '0));
    settle_block();
    write_reg(CfgCompactEnable, 32'd1);
    send_item(make_page(13, PlainType, '0, '0, '0, '0, '0));
    send_item(make_end());

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 24 : (ph == 1) ? 82 : 0;
      recv_idle = (ph == 0) ? 82 : (ph == 1) ? 24 : 0;
      for (int s = 0; s < 4; s++) begin
        settle_block();
        case (s)
          0:       apply_setting(1'b1, IndexPageTypeReset, $urandom);
          1:       apply_setting(1'b1, 16'h0000, '1);
          2:       apply_setting(1'b0, 16'hFFFF, 32'd1);
          default: apply_setting(1'b1, 16'($urandom), $urandom_range(1, 64));
        endcase
        seg_end = items_sent + 110;
        while (items_sent < seg_end) run_space($urandom_range(4, 24));
      end
    end

    // Page 3 without the index type switches compaction off for good, so
    // this comes last.
    settle_block();
    apply_setting(1'b1, IndexPageTypeReset, 32'd7);
    send_item(make_page(0, PlainType, 32'd5, '0, '0, '0, '0));
    send_item(make_page(6, IndexPageTypeReset, '0, 64'd9, '0, '0, '0));
    send_item(make_page(3, other_type(), '0, '0, '0, '0, '0));
    send_item(make_page(7, PlainType, '0, '0, '0, '0, '0));
    send_item(make_page(4, IndexPageTypeReset, '0, 64'd9, '0, '0, '0));
    send_item(make_end());
    settle_block();

    if (mismatches == 0 && results_due == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
